### src/ukrt_pkg.sv
// ----------------------------------------------------------------------------
// ukrt_pkg
// Shared types and constants of the unique-key record table: command and
// status codes, record and result layouts, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ukrt_pkg;

  // field widths
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned SAL_W  = 40;
  localparam int unsigned NAME_W = 64;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned TOT_W  = 45;

  // request queue between front and sequencer (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_LIST   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_DUP        = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_FULL       = 3'd3,
    ST_LIST_ENTRY = 3'd4,
    ST_LIST_END   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_LIST
  } seq_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SAL_W-1:0]  salary;
    logic [NAME_W-1:0] name;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  typedef struct packed {
    kind_e kind;
    rec_t  rec;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    rec_t              rec;
    logic [CNT_W-1:0]  count;
    logic [TOT_W-1:0]  total;
    logic              last;
  } res_t;

  // sequencer -> table control
  typedef struct packed {
    logic capture;  // register the key match of the queue head
    logic insert;   // push new record at the newest end
    logic remove;   // drop the matched record and close the gap
  } store_op_t;

  // table -> sequencer status
  typedef struct packed {
    logic hit;
    logic full;
  } store_stat_t;

endpackage

`default_nettype wire

### src/unique_key_record_table_top.sv
// ----------------------------------------------------------------------------
// unique_key_record_table_top
// Bounded table of unique-key records with insert, delete, search and list.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid_i/in_stall_o  | kind, key, salary, name
//   out     | output    | out_valid_o/out_stall_i| status, record, count, total
//
// Insert, delete and search run in the sequencer in order: the key match of
// all slots is registered, then the command executes and loads its result.
// A list loads one result per cycle into the single output register while
// not stalled: one entry per stored record as the slots are walked, then a summary.
// A two-entry request queue keeps taking requests while the sequencer works.
// A stalled result freezes the sequencer; reset clears slot valid bits,
// count and total at once, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_key_record_table_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        kind_i,
  input  logic signed [ukrt_pkg::KEY_W-1:0] key_i,
  input  logic [ukrt_pkg::SAL_W-1:0]        salary_cents_i,
  input  logic [ukrt_pkg::NAME_W-1:0]       name_chars_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        status_o,
  output logic signed [ukrt_pkg::KEY_W-1:0] rec_key_o,
  output logic [ukrt_pkg::SAL_W-1:0]        rec_salary_o,
  output logic [ukrt_pkg::NAME_W-1:0]       rec_name_o,
  output logic [ukrt_pkg::CNT_W-1:0]        record_count_o,
  output logic [ukrt_pkg::TOT_W-1:0]        salary_total_o,
  output logic                              last_o
);
  import ukrt_pkg::*;

  logic                   head_valid;
  cmd_t                   head;
  logic                   pop;
  store_op_t              op;
  rec_t                   new_rec;
  logic [TABLE_DEPTH-1:0] list_sel;
  store_stat_t            stat;
  rec_t                   hit_rec;
  rec_t                   list_rec;
  logic [TABLE_DEPTH-1:0] valid;
  logic [CNT_W-1:0]       count;
  logic [TOT_W-1:0]       total;
  res_t                   res;

  ukrt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .key_i          (key_i),
    .salary_cents_i (salary_cents_i),
    .name_chars_i   (name_chars_i),
    .pop_i          (pop),
    .head_valid_o   (head_valid),
    .head_o         (head)
  );

  ukrt_store #(
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .cmp_key_i  (head.rec.key),
    .new_rec_i  (new_rec),
    .list_sel_i (list_sel),
    .stat_o     (stat),
    .hit_rec_o  (hit_rec),
    .list_rec_o (list_rec),
    .valid_o    (valid),
    .count_o    (count),
    .total_o    (total)
  );

  ukrt_seq #(
    .DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .op_o         (op),
    .new_rec_o    (new_rec),
    .list_sel_o   (list_sel),
    .stat_i       (stat),
    .hit_rec_i    (hit_rec),
    .list_rec_i   (list_rec),
    .valid_i      (valid),
    .count_i      (count),
    .total_i      (total),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign status_o       = res.status;
  assign rec_key_o      = res.rec.key;
  assign rec_salary_o   = res.rec.salary;
  assign rec_name_o     = res.rec.name;
  assign record_count_o = res.count;
  assign salary_total_o = res.total;
  assign last_o         = res.last;

endmodule

`default_nettype wire

### src/ukrt_front.sv
// ----------------------------------------------------------------------------
// ukrt_front
// Accepts requests, decodes the command kind and holds them in a short
// queue so the sequencer can stall without blocking the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module ukrt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic signed [ukrt_pkg::KEY_W-1:0] key_i,
  input  logic [ukrt_pkg::SAL_W-1:0]  salary_cents_i,
  input  logic [ukrt_pkg::NAME_W-1:0] name_chars_i,
  input  logic                        pop_i,
  output logic                        head_valid_o,
  output ukrt_pkg::cmd_t              head_o
);
  import ukrt_pkg::*;

  cmd_t                q_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, wr_d;
  logic [QUEUE_AW-1:0] rd_q, rd_d;
  logic [QUEUE_AW:0]   fill_q, fill_d;
  cmd_t                in_cmd;
  logic                push;
  logic                pop;

  // classify the incoming request
  assign in_cmd.kind       = kind_e'(kind_i);
  assign in_cmd.rec.key    = key_i;
  assign in_cmd.rec.salary = salary_cents_i;
  assign in_cmd.rec.name   = name_chars_i;

  assign in_stall_o   = (fill_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign head_valid_o = (fill_q != '0);
  assign head_o       = q_q[rd_q];

  assign push = in_valid_i & ~in_stall_o;
  assign pop  = pop_i & head_valid_o;

  // pointers wrap naturally, depth is a power of two
  always_comb begin
    wr_d   = push ? wr_q + 1'b1 : wr_q;
    rd_d   = pop  ? rd_q + 1'b1 : rd_q;
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

### src/ukrt_store.sv
// ----------------------------------------------------------------------------
// ukrt_store
// Record slots in age order, newest at slot 0. Compares all keys at once,
// shifts on insert, closes the gap on delete, keeps count and salary total.
// ----------------------------------------------------------------------------
`default_nettype none

module ukrt_store #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ukrt_pkg::store_op_t         op_i,
  input  logic [ukrt_pkg::KEY_W-1:0]  cmp_key_i,
  input  ukrt_pkg::rec_t              new_rec_i,
  input  logic [DEPTH-1:0]            list_sel_i,
  output ukrt_pkg::store_stat_t       stat_o,
  output ukrt_pkg::rec_t              hit_rec_o,
  output ukrt_pkg::rec_t              list_rec_o,
  output logic [DEPTH-1:0]            valid_o,
  output logic [ukrt_pkg::CNT_W-1:0]  count_o,
  output logic [ukrt_pkg::TOT_W-1:0]  total_o
);
  import ukrt_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  rec_t             slot_q  [DEPTH];
  rec_t             slot_d  [DEPTH];
  logic [DEPTH-1:0] valid_q, valid_d;
  logic [DEPTH-1:0] match_q, match_d;
  logic [DEPTH-1:0] after;
  logic [CW-1:0]    count_q, count_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic [CW+CNT_W-1:0] count_wide;
  logic [REC_W-1:0] hit_vec;
  logic [REC_W-1:0] list_vec;

  // parallel key compare against every valid slot
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = valid_q[i] & (slot_q[i].key == cmp_key_i);
    end
  end

  // slot at the hit and every older one take their older neighbor
  assign after = ~(match_q - {{(DEPTH-1){1'b0}}, 1'b1});

  // one-hot AND-OR readout for the hit and the list pointer
  always_comb begin
    hit_vec  = '0;
    list_vec = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_vec  = hit_vec  | (slot_q[i] & {REC_W{match_q[i]}});
      list_vec = list_vec | (slot_q[i] & {REC_W{list_sel_i[i]}});
    end
  end

  assign hit_rec_o  = rec_t'(hit_vec);
  assign list_rec_o = rec_t'(list_vec);

  // per-slot next value
  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    rec_t down_rec;
    logic down_valid;
    rec_t up_rec;
    logic up_valid;

    if (g == 0) begin : g_bot
      assign down_rec   = new_rec_i;
      assign down_valid = 1'b1;
    end else begin : g_low
      assign down_rec   = slot_q[g-1];
      assign down_valid = valid_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_top
      assign up_rec   = slot_q[g];
      assign up_valid = 1'b0;
    end else begin : g_high
      assign up_rec   = slot_q[g+1];
      assign up_valid = valid_q[g+1];
    end

    always_comb begin
      priority if (op_i.insert) begin
        slot_d[g]  = down_rec;
        valid_d[g] = down_valid;
      end else if (op_i.remove && after[g]) begin
        slot_d[g]  = up_rec;
        valid_d[g] = up_valid;
      end else begin
        slot_d[g]  = slot_q[g];
        valid_d[g] = valid_q[g];
      end
    end
  end

  // count and salary total follow the stored records
  always_comb begin
    priority if (op_i.insert) begin
      count_d = count_q + CW'(1);
      total_d = total_q + {{(TOT_W-SAL_W){1'b0}}, new_rec_i.salary};
    end else if (op_i.remove) begin
      count_d = count_q - CW'(1);
      total_d = total_q - {{(TOT_W-SAL_W){1'b0}}, hit_rec_o.salary};
    end else begin
      count_d = count_q;
      total_d = total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      match_q <= '0;
      count_q <= '0;
      total_q <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      total_q <= total_d;
      if (op_i.capture) begin
        match_q <= match_d;
      end
    end
  end

  // record payload, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign count_wide  = {{CNT_W{1'b0}}, count_q};
  assign count_o     = count_wide[CNT_W-1:0];
  assign total_o     = total_q;
  assign valid_o     = valid_q;
  assign stat_o.hit  = |match_q;
  assign stat_o.full = valid_q[DEPTH-1];

endmodule

`default_nettype wire

### src/ukrt_seq.sv
// ----------------------------------------------------------------------------
// ukrt_seq
// Back-end sequencer: takes one queued request at a time, drives the table
// and loads results into the output register, walking the slots for a list.
// ----------------------------------------------------------------------------
`default_nettype none

module ukrt_seq #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  ukrt_pkg::cmd_t              head_i,
  output logic                        pop_o,
  output ukrt_pkg::store_op_t         op_o,
  output ukrt_pkg::rec_t              new_rec_o,
  output logic [DEPTH-1:0]            list_sel_o,
  input  ukrt_pkg::store_stat_t       stat_i,
  input  ukrt_pkg::rec_t              hit_rec_i,
  input  ukrt_pkg::rec_t              list_rec_i,
  input  logic [DEPTH-1:0]            valid_i,
  input  logic [ukrt_pkg::CNT_W-1:0]  count_i,
  input  logic [ukrt_pkg::TOT_W-1:0]  total_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ukrt_pkg::res_t              res_o
);
  import ukrt_pkg::*;

  seq_e             state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [DEPTH-1:0] ptr_q, ptr_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;
  logic             out_free;
  logic             out_load;
  logic             list_more;

  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign list_more = |(ptr_q & valid_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (head_valid_i) begin
          state_d = (head_i.kind == KIND_LIST) ? SQ_LIST : SQ_EXEC;
        end
      end
      SQ_EXEC: begin
        if (out_free) begin
          state_d = SQ_IDLE;
        end
      end
      SQ_LIST: begin
        if (out_free && !list_more) begin
          state_d = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // outputs: table control, result load, list pointer
  always_comb begin
    pop_o    = 1'b0;
    op_o     = '0;
    out_load = 1'b0;
    res_d    = '0;
    cmd_d    = cmd_q;
    ptr_d    = ptr_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (head_valid_i) begin
          pop_o      = 1'b1;
          op_o.capture = 1'b1;
          cmd_d      = head_i;
          ptr_d      = {{(DEPTH-1){1'b0}}, 1'b1};
        end
      end
      SQ_EXEC: begin
        out_load   = out_free;
        res_d.last = 1'b1;
        unique case (cmd_q.kind)
          KIND_INSERT: begin
            priority if (stat_i.hit) begin
              res_d.status = ST_DUP;
            end else if (stat_i.full) begin
              res_d.status = ST_FULL;
            end else begin
              res_d.status = ST_OK;
              op_o.insert  = out_free;
            end
          end
          KIND_DELETE: begin
            if (stat_i.hit) begin
              res_d.status = ST_OK;
              op_o.remove  = out_free;
            end else begin
              res_d.status = ST_NOT_FOUND;
            end
          end
          KIND_SEARCH: begin
            if (stat_i.hit) begin
              res_d.status = ST_OK;
              res_d.rec    = hit_rec_i;
            end else begin
              res_d.status = ST_NOT_FOUND;
            end
          end
          KIND_LIST: begin
            // lists never come through here
            res_d.status = ST_OK;
          end
          default: res_d.status = ST_OK;
        endcase
      end
      SQ_LIST: begin
        out_load = out_free;
        if (list_more) begin
          res_d.status = ST_LIST_ENTRY;
          res_d.rec    = list_rec_i;
          res_d.last   = 1'b0;
        end else begin
          res_d.status = ST_LIST_END;
          res_d.count  = count_i;
          res_d.total  = total_i;
          res_d.last   = 1'b1;
        end
        if (out_free) begin
          ptr_d = {ptr_q[DEPTH-2:0], 1'b0};
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // result register holds while stalled
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign new_rec_o   = cmd_q.rec;
  assign list_sel_o  = ptr_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### src/ukrt_checker.sv
// ----------------------------------------------------------------------------
// ukrt_checker
// Port-level checks of the record table's result stream, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ukrt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [2:0]                        status_o,
  input logic signed [ukrt_pkg::KEY_W-1:0] rec_key_o,
  input logic [ukrt_pkg::CNT_W-1:0]        record_count_o,
  input logic [ukrt_pkg::TOT_W-1:0]        salary_total_o,
  input logic                              last_o
);
  import ukrt_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(rec_key_o))
    else $error("stalled result changed");

  // only list entries leave the request open
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (status_o != ST_LIST_ENTRY)))
    else $error("last flag does not match status");

  // count and total appear on list end only
  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_LIST_END) |-> (record_count_o == '0) && (salary_total_o == '0))
    else $error("count or total outside list end");

  // a completed list entry is followed at once by more of the same list
  a_list_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (status_o == ST_LIST_ENTRY) |=> out_valid_o &&
      ((status_o == ST_LIST_ENTRY) || (status_o == ST_LIST_END)))
    else $error("list continuation broken");

endmodule

bind unique_key_record_table_top ukrt_checker u_ukrt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .rec_key_o      (rec_key_o),
  .record_count_o (record_count_o),
  .salary_total_o (salary_total_o),
  .last_o         (last_o)
);

`default_nettype wire

### verif/ukrt_table_checker.sv
// ----------------------------------------------------------------------------
// ukrt_table_checker
// Watches both channels of the unique-key record table, keeps its own copy of
// the table, predicts the replies of each accepted request and compares every
// accepted reply field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module ukrt_table_checker #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [1:0]                        kind_i,
  input  logic [ukrt_pkg::KEY_W-1:0]        key_i,
  input  logic [ukrt_pkg::SAL_W-1:0]        salary_cents_i,
  input  logic [ukrt_pkg::NAME_W-1:0]       name_chars_i,
  // reply channel
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [2:0]                        status_i,
  input  logic [ukrt_pkg::KEY_W-1:0]        rec_key_i,
  input  logic [ukrt_pkg::SAL_W-1:0]        rec_salary_i,
  input  logic [ukrt_pkg::NAME_W-1:0]       rec_name_i,
  input  logic [ukrt_pkg::CNT_W-1:0]        record_count_i,
  input  logic [ukrt_pkg::TOT_W-1:0]        salary_total_i,
  input  logic                              last_i,
  // status toward the testbench top
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o,
  output int                                dup_seen_o,
  output int                                full_seen_o
);
  import ukrt_pkg::*;

  typedef struct {
    status_e           status;
    rec_t              rec;
    logic [CNT_W-1:0]  count;
    logic [TOT_W-1:0]  total;
    logic              last;
  } reply_t;

  // shadow table: entries 0..stored-1 are valid, newest at 0
  rec_t             shadow_rec [TABLE_DEPTH];
  int unsigned      shadow_stored;
  logic [TOT_W-1:0] shadow_total;

  reply_t replies_due [$];

  function automatic reply_t make_reply(status_e st, rec_t r, logic lst);
    reply_t rp;
    rp.status = st;
    rp.rec    = r;
    rp.count  = '0;
    rp.total  = '0;
    rp.last   = lst;
    return rp;
  endfunction

  function automatic int find_slot(logic [KEY_W-1:0] k);
    for (int i = 0; i < shadow_stored; i++)
      if (shadow_rec[i].key == k) return i;
    return -1;
  endfunction

  // Apply one request to the shadow table and queue the replies it causes.
  task automatic predict_replies(kind_e k, rec_t req);
    reply_t rp;
    int     hit;
    rec_t   none;
    none = '0;
    hit  = find_slot(req.key);
    case (k)
      KIND_INSERT: begin
        // duplicate check comes before the capacity check
        if (hit >= 0) begin
          replies_due.push_back(make_reply(ST_DUP, none, 1'b1));
          dup_seen_o++;
        end else if (shadow_stored >= TABLE_DEPTH) begin
          replies_due.push_back(make_reply(ST_FULL, none, 1'b1));
          full_seen_o++;
        end else begin
          for (int i = shadow_stored; i > 0; i--) shadow_rec[i] = shadow_rec[i-1];
          shadow_rec[0] = req;
          shadow_stored++;
          shadow_total += req.salary;
          replies_due.push_back(make_reply(ST_OK, none, 1'b1));
        end
      end
      KIND_DELETE: begin
        if (hit < 0) begin
          replies_due.push_back(make_reply(ST_NOT_FOUND, none, 1'b1));
        end else begin
          shadow_total -= shadow_rec[hit].salary;
          for (int i = hit; i + 1 < shadow_stored; i++) shadow_rec[i] = shadow_rec[i+1];
          shadow_stored--;
          replies_due.push_back(make_reply(ST_OK, none, 1'b1));
        end
      end
      KIND_SEARCH: begin
        if (hit < 0) replies_due.push_back(make_reply(ST_NOT_FOUND, none, 1'b1));
        else         replies_due.push_back(make_reply(ST_OK, shadow_rec[hit], 1'b1));
      end
      default: begin
        // list: every record newest first, then the closing summary
        for (int i = 0; i < shadow_stored; i++)
          replies_due.push_back(make_reply(ST_LIST_ENTRY, shadow_rec[i], 1'b0));
        rp       = make_reply(ST_LIST_END, none, 1'b1);
        rp.count = CNT_W'(shadow_stored);
        rp.total = shadow_total;
        replies_due.push_back(rp);
      end
    endcase
  endtask

  function automatic int field_diff(string label, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Replies are checked before the request of the same edge is predicted;
  // no reply can belong to a request accepted at that very edge.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    rec_t   req;
    int     errs;
    if (!rst_ni) begin
      shadow_stored = 0;
      shadow_total  = '0;
      replies_due.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      checked_o     = 0;
      dup_seen_o    = 0;
      full_seen_o   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply, status %0d, expected none", $time, status_i);
          fail_count_o++;
        end else begin
          want = replies_due.pop_front();
          errs = field_diff("status", 64'(want.status), 64'(status_i))
               + field_diff("rec_key", 64'(want.rec.key), 64'(rec_key_i))
               + field_diff("rec_salary", 64'(want.rec.salary), 64'(rec_salary_i))
               + field_diff("rec_name", want.rec.name, rec_name_i)
               + field_diff("record_count", 64'(want.count), 64'(record_count_i))
               + field_diff("salary_total", 64'(want.total), 64'(salary_total_i))
               + field_diff("last", 64'(want.last), 64'(last_i));
          if (errs != 0) fail_count_o++;
          checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        req.key    = key_i;
        req.salary = salary_cents_i;
        req.name   = name_chars_i;
        predict_replies(kind_e'(kind_i), req);
      end
      pending_o = replies_due.size();
    end
  end

endmodule

`default_nettype wire

### verif/tb_unique_key_record_table_top.sv
// ----------------------------------------------------------------------------
// tb_unique_key_record_table_top
// Drives insert, delete, search and list requests into the record table with
// random gaps and reply stalls; a checker beside the block predicts and
// compares every reply. Directed corner cases first, then random phases that
// fill, stress, drain and mix the table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_unique_key_record_table_top;
  import ukrt_pkg::*;

  localparam int unsigned DEPTH       = 32;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          HOLD_CYCLES = 200;
  localparam int          TAIL_CYCLES = 40;
  localparam int          POOL_SIZE   = 40;

  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  kind_e               req_kind   = KIND_INSERT;
  logic [KEY_W-1:0]    req_key    = '0;
  logic [SAL_W-1:0]    req_salary = '0;
  logic [NAME_W-1:0]   req_name   = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [2:0]          rsp_status;
  logic [KEY_W-1:0]    rsp_key;
  logic [SAL_W-1:0]    rsp_salary;
  logic [NAME_W-1:0]   rsp_name;
  logic [CNT_W-1:0]    rsp_count;
  logic [TOT_W-1:0]    rsp_total;
  logic                rsp_last;

  int fail_count, pending, checked, dup_seen, full_seen;
  int cycle_cnt;
  int n_sent  = 0;
  int n_lists = 0;

  bit sender_idle_en = 1'b1;
  bit rcv_idle_en    = 1'b1;
  bit hold_req       = 1'b0;
  bit hold_done      = 1'b0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  unique_key_record_table_top #(
    .TABLE_DEPTH (DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (req_kind),
    .key_i          (req_key),
    .salary_cents_i (req_salary),
    .name_chars_i   (req_name),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (rsp_status),
    .rec_key_o      (rsp_key),
    .rec_salary_o   (rsp_salary),
    .rec_name_o     (rsp_name),
    .record_count_o (rsp_count),
    .salary_total_o (rsp_total),
    .last_o         (rsp_last)
  );

  ukrt_table_checker #(
    .TABLE_DEPTH (DEPTH)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .kind_i         (req_kind),
    .key_i          (req_key),
    .salary_cents_i (req_salary),
    .name_chars_i   (req_name),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (rsp_status),
    .rec_key_i      (rsp_key),
    .rec_salary_i   (rsp_salary),
    .rec_name_i     (rsp_name),
    .record_count_i (rsp_count),
    .salary_total_i (rsp_total),
    .last_i         (rsp_last),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .dup_seen_o     (dup_seen),
    .full_seen_o    (full_seen)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d replies still due", cycle_cnt, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // reply side: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall = 1'b0;
        hold_done = 1'b1;
      end else if (rcv_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_stall = 1'b0;
      end
    end
  end

  // Present one request at the falling edge, optionally after a gap, and
  // hold it until the block takes it.
  task automatic send_request(kind_e k, logic [KEY_W-1:0] key,
                              logic [SAL_W-1:0] sal, logic [NAME_W-1:0] name);
    @(negedge clk_i);
    if (sender_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid   = 1'b1;
    req_kind   = k;
    req_key    = key;
    req_salary = sal;
    req_name   = name;
    do @(posedge clk_i); while (in_stall);
    n_sent++;
    if (k == KIND_LIST) n_lists++;
  endtask

  // Drop valid and wait until every predicted reply has been seen.
  task automatic drain_replies();
    @(negedge clk_i);
    in_valid = 1'b0;
    wait (pending == 0);
  endtask

  // mostly keys from a small pool so hits, duplicates and a full table occur
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 4) != 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  function automatic logic [SAL_W-1:0] pick_salary();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SAL_W'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [NAME_W-1:0] pick_name();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic random_request(int w_ins, int w_del, int w_srch, int w_list);
    int    roll;
    kind_e k;
    roll = $urandom_range(0, w_ins + w_del + w_srch + w_list - 1);
    if (roll < w_ins)                      k = KIND_INSERT;
    else if (roll < w_ins + w_del)         k = KIND_DELETE;
    else if (roll < w_ins + w_del + w_srch) k = KIND_SEARCH;
    else                                   k = KIND_LIST;
    send_request(k, pick_key(), pick_salary(), pick_name());
  endtask

  // stimulus and verdict
  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, field extremes, duplicate, misses, removal
    send_request(KIND_LIST,   '0,           '0, '0);
    send_request(KIND_SEARCH, 32'h0,        '0, '0);
    send_request(KIND_DELETE, 32'h1234_5678, '0, '0);
    send_request(KIND_INSERT, 32'h8000_0000, '1, '1);
    send_request(KIND_INSERT, 32'h7FFF_FFFF, '0, '0);
    send_request(KIND_INSERT, 32'hFFFF_FFFF, 40'h00_DEAD_BEEF, 64'h4142_4344_4546_4748);
    send_request(KIND_INSERT, 32'h0,        40'h55_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(KIND_INSERT, 32'h8000_0000, 40'h1, 64'h1);
    send_request(KIND_SEARCH, 32'h7FFF_FFFF, '0, '0);
    send_request(KIND_SEARCH, 32'h8000_0000, '1, '1);
    send_request(KIND_LIST,   '0,           '0, '0);
    send_request(KIND_DELETE, 32'hFFFF_FFFF, '0, '0);
    send_request(KIND_DELETE, 32'hFFFF_FFFF, '0, '0);
    send_request(KIND_SEARCH, 32'hFFFF_FFFF, '0, '0);
    send_request(KIND_DELETE, 32'h8000_0000, '0, '0);
    send_request(KIND_LIST,   '1,           '1, '1);

    // fill: insert-heavy until the table is full and refusing
    repeat (100) random_request(70, 5, 15, 10);

    // long reply hold-off while requests keep coming
    hold_req = 1'b1;
    repeat (60) random_request(40, 20, 30, 10);

    // sender pause until everything has come back
    drain_replies();

    // drain: delete-heavy, to shrink the table
    repeat (120) random_request(15, 60, 15, 10);

    // mixed traffic
    repeat (120) random_request(35, 30, 27, 8);

    // last part without any idling
    sender_idle_en = 1'b0;
    rcv_idle_en    = 1'b0;
    repeat (80) random_request(40, 25, 25, 10);

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (%0d lists); %0d replies checked", n_sent, n_lists, checked);
    $display("Refused inserts: %0d duplicate key, %0d table full", dup_seen, full_seen);
    if (fail_count == 0) $display("Testbench completed without errors");
    else                 $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
